[rtl/bfd_pkg.sv]
`timescale 1ns / 1ps

package bfd_pkg;

    // CRC-16, polynomial 0x1021, initial value 0, no reflection
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    // Header byte 0xDC..0xDF: top six bits fixed, low two carry the type
    localparam logic [7:0] HDR_MASK = 8'hFC;
    localparam logic [7:0] HDR_MARK = 8'hDC;

    // Shortest frame: header, source, destination, length, two CRC bytes
    localparam logic [7:0] MIN_FRAME_LEN = 8'd6;
    // Number of CRC bytes that end a frame, after the payload
    localparam logic [7:0] CRC_BYTES = 8'd2;
    // Bytes taken when the length byte has been consumed
    localparam logic [7:0] HDR_BYTES = 8'd4;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_ACCEPT = 2'd2,
        KIND_REJECT = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_HEADER   = 3'd1,
        ERR_SRC_MARK = 3'd2,
        ERR_DST_MARK = 3'd3,
        ERR_LEN      = 3'd4,
        ERR_CRC      = 3'd5
    } err_t;

endpackage

[rtl/bus_frame_deframer_crc16_unit.sv]
`timescale 1ns / 1ps

// An rx_byte goes to the input register, then its result to the result register.
// Throughput: one item per cycle from one input register and one CRC byte step;
// a held result fills the input register, and out_stall then stalls the input.
// Reset: rst_n is asynchronous, active low; it empties both stages and puts
// the parser back to hunting for a header with a cleared CRC.
module bus_frame_deframer_crc16_unit
    import bfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,

    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] payload_byte,
    output logic [1:0] frame_type,
    output logic [6:0] source_address,
    output logic [6:0] dest_address,
    output logic [7:0] payload_length,
    output logic [2:0] error_code
);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_SRC,
        PH_DST,
        PH_LEN,
        PH_DATA,
        PH_CRC_HI,
        PH_CRC_LO
    } phase_t;

    // Input stage
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;

    // Parser state
    phase_t      phase_reg,     phase_next;
    logic [7:0]  byte_pos_reg,  byte_pos_next;
    logic [7:0]  frame_len_reg, frame_len_next;
    logic [15:0] crc_reg,       crc_next;
    logic [1:0]  held_type_reg, held_type_next;
    logic [6:0]  held_src_reg,  held_src_next;
    logic [6:0]  held_dst_reg,  held_dst_next;
    logic [7:0]  crc_hi_reg,    crc_hi_next;

    // Result register
    logic       out_valid_reg;
    logic [1:0] kind_reg,     kind_next;
    logic [7:0] pay_byte_reg, pay_byte_next;
    logic [1:0] ftype_reg,    ftype_next;
    logic [6:0] src_reg,      src_next;
    logic [6:0] dst_reg,      dst_next;
    logic [7:0] pay_len_reg,  pay_len_next;
    logic [2:0] err_reg,      err_next;

    logic        out_ready;
    logic        s1_fire;
    logic [15:0] crc_seed;
    logic [15:0] crc_upd;
    logic [7:0]  b;

    // The result register takes a new item when empty or when its item leaves.
    // The input stage refills whenever its item moves on, so a new byte enters
    // every cycle as long as the output keeps draining.
    assign out_ready = !out_valid_reg || !out_stall;
    assign s1_fire   = s1_valid_reg && out_ready;
    assign in_stall  = s1_valid_reg && !out_ready;

    assign b = s1_byte_reg;

    // A header byte restarts the CRC from its initial value
    assign crc_seed = (phase_reg == PH_HUNT) ? CRC_INIT : crc_reg;

    bfd_crc16_step u_crc
    (
        .crc_in  (crc_seed),
        .data    (b),
        .crc_out (crc_upd)
    );

    // Parse one byte: next parser state and the result it produces.
    always_comb
    begin
        phase_next     = phase_reg;
        byte_pos_next  = byte_pos_reg;
        frame_len_next = frame_len_reg;
        crc_next       = crc_reg;
        held_type_next = held_type_reg;
        held_src_next  = held_src_reg;
        held_dst_next  = held_dst_reg;
        crc_hi_next    = crc_hi_reg;

        kind_next     = KIND_NONE;
        pay_byte_next = 8'h00;
        ftype_next    = 2'd0;
        src_next      = 7'd0;
        dst_next      = 7'd0;
        pay_len_next  = 8'h00;
        err_next      = ERR_NONE;

        case (phase_reg)
            PH_HUNT:
            begin
                // Drop whatever was held; a rejected non-header reports zeros
                held_src_next = 7'd0;
                held_dst_next = 7'd0;
                if ((b & HDR_MASK) != HDR_MARK)
                begin
                    held_type_next = 2'd0;
                    kind_next      = KIND_REJECT;
                    err_next       = ERR_HEADER;
                end
                else
                begin
                    held_type_next = b[1:0];
                    crc_next       = crc_upd;
                    phase_next     = PH_SRC;
                end
            end

            PH_SRC:
            begin
                if (!b[7])
                begin
                    kind_next  = KIND_REJECT;
                    err_next   = ERR_SRC_MARK;
                    phase_next = PH_HUNT;
                end
                else
                begin
                    held_src_next = b[6:0];
                    crc_next      = crc_upd;
                    phase_next    = PH_DST;
                end
            end

            PH_DST:
            begin
                if (b[7])
                begin
                    kind_next  = KIND_REJECT;
                    err_next   = ERR_DST_MARK;
                    phase_next = PH_HUNT;
                end
                else
                begin
                    held_dst_next = b[6:0];
                    crc_next      = crc_upd;
                    phase_next    = PH_LEN;
                end
            end

            PH_LEN:
            begin
                if (b < MIN_FRAME_LEN)
                begin
                    kind_next  = KIND_REJECT;
                    err_next   = ERR_LEN;
                    phase_next = PH_HUNT;
                end
                else
                begin
                    frame_len_next = b;
                    crc_next       = crc_upd;
                    byte_pos_next  = HDR_BYTES;
                    // A frame with no payload goes straight to its CRC
                    phase_next     = (b == MIN_FRAME_LEN) ? PH_CRC_HI : PH_DATA;
                end
            end

            PH_DATA:
            begin
                crc_next      = crc_upd;
                byte_pos_next = byte_pos_reg + 8'd1;
                if (byte_pos_next == frame_len_reg - CRC_BYTES)
                begin
                    phase_next = PH_CRC_HI;
                end
                kind_next     = KIND_DATA;
                pay_byte_next = b;
            end

            PH_CRC_HI:
            begin
                crc_hi_next = b;
                phase_next  = PH_CRC_LO;
            end

            PH_CRC_LO:
            begin
                phase_next = PH_HUNT;
                if ({crc_hi_reg, b} != crc_reg)
                begin
                    kind_next = KIND_REJECT;
                    err_next  = ERR_CRC;
                end
                else
                begin
                    kind_next    = KIND_ACCEPT;
                    pay_len_next = frame_len_reg - MIN_FRAME_LEN;
                end
            end

            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase

        // Frame-end results carry what was captured so far; a header
        // rejection carries zeros since held fields were just cleared
        if (kind_next == KIND_ACCEPT || kind_next == KIND_REJECT)
        begin
            ftype_next = held_type_next;
            src_next   = held_src_next;
            dst_next   = held_dst_next;
        end
    end

    // Hold state and registered outputs; advance only when the item moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_HUNT;
            byte_pos_reg  <= 8'h00;
            frame_len_reg <= 8'h00;
            crc_reg       <= CRC_INIT;
            held_type_reg <= 2'd0;
            held_src_reg  <= 7'd0;
            held_dst_reg  <= 7'd0;
            crc_hi_reg    <= 8'h00;
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
                s1_byte_reg  <= rx_byte;
            end

            if (out_ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end

            if (s1_fire)
            begin
                phase_reg     <= phase_next;
                byte_pos_reg  <= byte_pos_next;
                frame_len_reg <= frame_len_next;
                crc_reg       <= crc_next;
                held_type_reg <= held_type_next;
                held_src_reg  <= held_src_next;
                held_dst_reg  <= held_dst_next;
                crc_hi_reg    <= crc_hi_next;

                kind_reg     <= kind_next;
                pay_byte_reg <= pay_byte_next;
                ftype_reg    <= ftype_next;
                src_reg      <= src_next;
                dst_reg      <= dst_next;
                pay_len_reg  <= pay_len_next;
                err_reg      <= err_next;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign payload_byte   = pay_byte_reg;
    assign frame_type     = ftype_reg;
    assign source_address = src_reg;
    assign dest_address   = dst_reg;
    assign payload_length = pay_len_reg;
    assign error_code     = err_reg;

    // Stall the input only while the input stage holds an item
    a_stall_needs_item: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg
    ) else $error("input stalled with an empty input stage");

    // Only a rejection carries an error code
    a_err_only_on_reject: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && kind != KIND_REJECT) |-> (error_code == ERR_NONE)
    ) else $error("error code on a non-reject result");

    // While in payload the byte count stays short of the CRC bytes
    a_data_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |->
            (({1'b0, byte_pos_reg} + {1'b0, CRC_BYTES}) < {1'b0, frame_len_reg})
    ) else $error("payload count ran past the frame length");

    // An accepted frame never reports more payload than a length byte allows
    a_accept_len: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_ACCEPT) |-> (payload_length <= 8'd249)
    ) else $error("accepted frame with impossible payload length");

endmodule

[rtl/bfd_crc16_step.sv]
`timescale 1ns / 1ps

// One byte of CRC-16 (MSB first), eight shift steps of a 16-bit value.
module bfd_crc16_step
    import bfd_pkg::*;
(
    input  logic [15:0] crc_in,
    input  logic [7:0]  data,
    output logic [15:0] crc_out
);

    always_comb
    begin
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        crc_out = c;
    end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
    import bfd_pkg::*;

    localparam int ITEM_TARGET  = 1100;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 12;
    localparam int LONG_HOLD    = 300;
    localparam int CALM_TAIL    = 150;

    // Frame parser states of the local predictor
    typedef enum logic [2:0] {
        PS_HUNT,
        PS_SRC,
        PS_DST,
        PS_LEN,
        PS_DATA,
        PS_CRC_HI,
        PS_CRC_LO
    } parse_state_t;

    // One expected deframer result, field for field as on the output ports
    typedef struct packed {
        kind_t      kind;
        logic [7:0] payload;
        logic [1:0] ftype;
        logic [6:0] src;
        logic [6:0] dst;
        logic [7:0] plen;
        err_t       err;
    } deframe_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic [1:0] frame_type;
    logic [6:0] source_address;
    logic [6:0] dest_address;
    logic [7:0] payload_length;
    logic [2:0] error_code;

    bus_frame_deframer_crc16_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .payload_byte   (payload_byte),
        .frame_type     (frame_type),
        .source_address (source_address),
        .dest_address   (dest_address),
        .payload_length (payload_length),
        .error_code     (error_code)
    );

    // Bus bytes waiting to be offered, and results the block still owes
    logic [7:0]      rx_pending[$];
    deframe_result_t result_q[$];
    deframe_result_t due;

    int total_items = 0;
    int fail_count = 0;
    int checked_count = 0;
    int cycle_count = 0;
    int send_gap = 0;
    int stall_left = 0;
    bit long_hold_done = 1'b0;

    // Predictor state: mirrors the parser registers of the block
    parse_state_t parse_state = PS_HUNT;
    logic [7:0]   bytes_taken = 8'h00;
    logic [7:0]   total_len = 8'h00;
    logic [15:0]  running_crc = CRC_INIT;
    logic [1:0]   cap_type = 2'b00;
    logic [6:0]   cap_src = 7'h00;
    logic [6:0]   cap_dst = 7'h00;
    logic [7:0]   crc_high_byte = 8'h00;

    // One byte of CRC-16, polynomial 0x1021, MSB first
    function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        int          i;
        r = c ^ {b, 8'h00};
        for (i = 0; i < 8; i++)
        begin
            r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

    // Queue one expected result; end-of-frame kinds carry the captured header
    task automatic post_result(input kind_t k, input logic [7:0] data, input logic [7:0] len,
                               input err_t e);
        deframe_result_t r;
        bit              frame_end;
        frame_end = (k == KIND_ACCEPT) || (k == KIND_REJECT);
        r.kind    = k;
        r.payload = (k == KIND_DATA) ? data : 8'h00;
        r.ftype   = frame_end ? cap_type : 2'b00;
        r.src     = frame_end ? cap_src : 7'h00;
        r.dst     = frame_end ? cap_dst : 7'h00;
        r.plen    = (k == KIND_ACCEPT) ? len : 8'h00;
        r.err     = e;
        result_q.push_back(r);
    endtask

    task automatic reject_frame(input err_t e);
        post_result(KIND_REJECT, 8'h00, 8'h00, e);
        parse_state = PS_HUNT;
    endtask

    // Advance the predictor by one accepted bus byte
    task automatic deframe_step(input logic [7:0] b);
        case (parse_state)
            PS_SRC:
            begin
                if (!b[7])
                begin
                    reject_frame(ERR_SRC_MARK);
                end
                else
                begin
                    cap_src = b[6:0];
                    running_crc = crc16_step(running_crc, b);
                    parse_state = PS_DST;
                    post_result(KIND_NONE, 8'h00, 8'h00, ERR_NONE);
                end
            end
            PS_DST:
            begin
                if (b[7])
                begin
                    reject_frame(ERR_DST_MARK);
                end
                else
                begin
                    cap_dst = b[6:0];
                    running_crc = crc16_step(running_crc, b);
                    parse_state = PS_LEN;
                    post_result(KIND_NONE, 8'h00, 8'h00, ERR_NONE);
                end
            end
            PS_LEN:
            begin
                if (b < MIN_FRAME_LEN)
                begin
                    reject_frame(ERR_LEN);
                end
                else
                begin
                    total_len = b;
                    running_crc = crc16_step(running_crc, b);
                    bytes_taken = HDR_BYTES;
                    parse_state = (b == MIN_FRAME_LEN) ? PS_CRC_HI : PS_DATA;
                    post_result(KIND_NONE, 8'h00, 8'h00, ERR_NONE);
                end
            end
            PS_DATA:
            begin
                running_crc = crc16_step(running_crc, b);
                bytes_taken = bytes_taken + 8'd1;
                if (bytes_taken == 8'(total_len - CRC_BYTES))
                begin
                    parse_state = PS_CRC_HI;
                end
                post_result(KIND_DATA, b, 8'h00, ERR_NONE);
            end
            PS_CRC_HI:
            begin
                crc_high_byte = b;
                parse_state = PS_CRC_LO;
                post_result(KIND_NONE, 8'h00, 8'h00, ERR_NONE);
            end
            PS_CRC_LO:
            begin
                if ({crc_high_byte, b} != running_crc)
                begin
                    reject_frame(ERR_CRC);
                end
                else
                begin
                    post_result(KIND_ACCEPT, 8'h00, 8'(total_len - MIN_FRAME_LEN), ERR_NONE);
                    parse_state = PS_HUNT;
                end
            end
            default:
            begin
                // Hunting: anything but 0xDC..0xDF is dropped with a header error
                cap_src = 7'h00;
                cap_dst = 7'h00;
                if ((b & HDR_MASK) != HDR_MARK)
                begin
                    cap_type = 2'b00;
                    reject_frame(ERR_HEADER);
                end
                else
                begin
                    cap_type = b[1:0];
                    running_crc = crc16_step(CRC_INIT, b);
                    parse_state = PS_SRC;
                    post_result(KIND_NONE, 8'h00, 8'h00, ERR_NONE);
                end
            end
        endcase
    endtask

    // Append a whole frame with random payload; crc_flip corrupts the trailer
    task automatic push_frame(input logic [7:0] hdr, input logic [7:0] src,
                              input logic [7:0] dst, input logic [7:0] len,
                              input logic [15:0] crc_flip);
        logic [15:0] c;
        logic [7:0]  pb;
        int          i;
        c = crc16_step(CRC_INIT, hdr);
        c = crc16_step(c, src);
        c = crc16_step(c, dst);
        c = crc16_step(c, len);
        rx_pending.push_back(hdr);
        rx_pending.push_back(src);
        rx_pending.push_back(dst);
        rx_pending.push_back(len);
        for (i = 0; i < int'(len) - 6; i++)
        begin
            pb = 8'($urandom_range(0, 255));
            c = crc16_step(c, pb);
            rx_pending.push_back(pb);
        end
        c = c ^ crc_flip;
        rx_pending.push_back(c[15:8]);
        rx_pending.push_back(c[7:0]);
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Build the whole byte stream, release reset, then wait for the drain
    initial
    begin
        logic [7:0] hdr;
        logic [7:0] src;
        logic [7:0] dst;
        logic [7:0] len;
        int         pick;

        // Directed: stray bytes, shortest and one-payload frames, each error
        rx_pending.push_back(8'h00);
        push_frame(8'hDC, 8'h80, 8'h00, 8'd6, 16'h0000);
        push_frame(8'hDF, 8'hFF, 8'h7F, 8'd7, 16'h0000);
        rx_pending.push_back(8'hDD);
        rx_pending.push_back(8'h7F);
        // Offending destination looks like a header: it must be consumed
        rx_pending.push_back(8'hDE);
        rx_pending.push_back(8'h81);
        rx_pending.push_back(8'hDC);
        rx_pending.push_back(8'hDC);
        rx_pending.push_back(8'h80);
        rx_pending.push_back(8'h01);
        rx_pending.push_back(8'h05);
        push_frame(8'hDF, 8'hC3, 8'h2A, 8'd6, 16'h0001);

        // Random: mostly good frames, some bad CRCs, broken headers and noise
        while (rx_pending.size() < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            hdr = HDR_MARK | 8'($urandom_range(0, 3));
            src = {1'b1, 7'($urandom_range(0, 127))};
            dst = {1'b0, 7'($urandom_range(0, 127))};
            if ($urandom_range(0, 59) == 0)
            begin
                len = 8'($urandom_range(6, 255));
            end
            else
            begin
                len = 8'($urandom_range(6, 16));
            end

            if (pick < 72)
            begin
                push_frame(hdr, src, dst, len, 16'h0000);
            end
            else if (pick < 82)
            begin
                push_frame(hdr, src, dst, len, 16'(1) << $urandom_range(0, 15));
            end
            else if (pick < 90)
            begin
                rx_pending.push_back(hdr);
                case ($urandom_range(0, 2))
                    0:
                    begin
                        rx_pending.push_back({1'b0, src[6:0]});
                    end
                    1:
                    begin
                        rx_pending.push_back(src);
                        rx_pending.push_back({1'b1, dst[6:0]});
                    end
                    default:
                    begin
                        rx_pending.push_back(src);
                        rx_pending.push_back(dst);
                        rx_pending.push_back(8'($urandom_range(0, 5)));
                    end
                endcase
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    rx_pending.push_back(8'($urandom_range(0, 255)));
                end
            end
        end
        total_items = rx_pending.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Poll on the falling edge so every clocked update has settled
        while (rx_pending.size() != 0 || in_valid || result_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    // Sender: offer the next byte once the current one is taken, idle in bursts
    always @(posedge clk or negedge rst_n)
    begin
        bit busy;
        bit idle_ok;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte <= 8'h00;
            send_gap <= 0;
        end
        else
        begin
            busy = in_valid;
            if (in_valid && !in_stall)
            begin
                deframe_step(rx_byte);
                busy = 1'b0;
            end
            // Keep stretches free of idling, and none near the end
            idle_ok = (rx_pending.size() > CALM_TAIL) && ((rx_pending.size() / 128) % 3 != 0);
            if (!busy)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (rx_pending.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (idle_ok && $urandom_range(0, 9) == 0)
                begin
                    send_gap <= $urandom_range(0, 17);
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_valid <= 1'b1;
                    rx_byte <= rx_pending.pop_front();
                end
            end
        end
    end

    // Receiver stall: random bursts, plus one long hold-off to back up the block
    always @(posedge clk or negedge rst_n)
    begin
        bit idle_ok;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
            long_hold_done <= 1'b0;
        end
        else
        begin
            idle_ok = (checked_count + CALM_TAIL < total_items)
                      && ((checked_count / 128) % 3 != 1);
            if (stall_left > 1)
            begin
                stall_left <= stall_left - 1;
            end
            else if (stall_left == 1)
            begin
                stall_left <= 0;
                out_stall <= 1'b0;
            end
            else if (!long_hold_done && checked_count >= 400)
            begin
                long_hold_done <= 1'b1;
                stall_left <= LONG_HOLD;
                out_stall <= 1'b1;
            end
            else if (idle_ok && $urandom_range(0, 11) == 0)
            begin
                stall_left <= $urandom_range(1, 18);
                out_stall <= 1'b1;
            end
        end
    end

    // Monitor: compare each taken result with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            checked_count <= 0;
        end
        else if (out_valid && !out_stall)
        begin
            if (result_q.size() == 0)
            begin
                $error("result with nothing expected: kind %0d", kind);
                fail_count++;
            end
            else
            begin
                due = result_q.pop_front();
                check_field("kind", 8'(due.kind), 8'(kind));
                check_field("payload_byte", due.payload, payload_byte);
                check_field("frame_type", 8'(due.ftype), 8'(frame_type));
                check_field("source_address", 8'(due.src), 8'(source_address));
                check_field("dest_address", 8'(due.dst), 8'(dest_address));
                check_field("payload_length", due.plen, payload_length);
                check_field("error_code", 8'(due.err), 8'(error_code));
            end
            checked_count <= checked_count + 1;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule
